// ===== rtl/fir_filter_direct_form_unit_assert.svh =====
// assertion macros shared by the fir filter rtl
// depends on nothing; the including module supplies clk and rst_n
`ifndef FIR_FILTER_DIRECT_FORM_UNIT_ASSERT_SVH
`define FIR_FILTER_DIRECT_FORM_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FIR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fir_pkg.sv =====
// shared constants and types for the direct-form fir filter
// no dependencies
`default_nettype none

package fir_pkg;

  // tap store geometry
  localparam int MAX_TAPS = 64;
  localparam int TAP_W    = $clog2(MAX_TAPS);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int OUT_W    = 40;
  localparam int TAPCNT_W = 7;
  localparam int IDX_W    = 6;

  // sample is consumed as two 8-bit digits, low digit first
  localparam int DIGIT_W  = 8;
  localparam int PROD_W   = COEF_W + DIGIT_W + 1;

  // register map
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = TAPCNT_W'(64);

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // control sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_WRAP = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/fir_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module fir_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/fir_filter_direct_form_unit.sv =====
// top level of the direct-form fir filter: delay line, coefficient ram, digit-serial mac
// depends on fir_pkg, fir_ram and fir_filter_direct_form_unit_assert.svh
//
//   port group | direction | transfer when          | carries
//   in_*       | in        | in_valid & in_ready   | req_type, coef_index, coef_value, sample_in
//   out_*      | out       | out_valid & out_ready | filtered_out
//   apb        | in        | psel&penable&pwrite   | tap_count at byte address 0
//
// a coefficient load completes at its transfer; a sample occupies the mac for every tap before the next item is taken
// the mac walks every tap, two 8-bit sample digits per tap, through one 18x9 multiplier
// a finished sum waits in the output register while the next item is taken
// rst_n is synchronous: it clears the delay line and coefficient valid bits and sets tap_count to 64
// in_ready drops while a sample is in the mac and while its sum waits for the output register
`default_nettype none

module fir_filter_direct_form_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_req_type,
  input  wire logic        [fir_pkg::IDX_W-1:0]    in_coef_index,
  input  wire logic signed [fir_pkg::COEF_W-1:0]   in_coef_value,
  input  wire logic signed [fir_pkg::SAMPLE_W-1:0] in_sample_in,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [fir_pkg::OUT_W-1:0]    out_filtered_out,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [fir_pkg::PADDR_W-1:0]  paddr,
  input  wire logic        [fir_pkg::PDATA_W-1:0]  pwdata,
  output logic             [fir_pkg::PDATA_W-1:0]  prdata,
  output logic                                     pready
);

  `include "fir_filter_direct_form_unit_assert.svh"

  localparam int TAP_W    = fir_pkg::TAP_W;
  localparam int TAPCNT_W = fir_pkg::TAPCNT_W;
  localparam int DIGIT_W  = fir_pkg::DIGIT_W;
  localparam int PROD_W   = fir_pkg::PROD_W;
  localparam int OUT_W    = fir_pkg::OUT_W;

  fir_pkg::state_t state_r, state_nxt;

  logic [TAPCNT_W-1:0]                 tap_count_r;
  logic signed [fir_pkg::SAMPLE_W-1:0] dl_r [fir_pkg::MAX_TAPS];
  logic [fir_pkg::MAX_TAPS-1:0]        coef_vld_r;

  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             digit_r, digit_nxt;

  logic                      s1_vld_r, s1_hi_r, s1_en_r;
  logic signed [DIGIT_W:0]   s1_digit_r;
  logic                      vld_rd_r;
  logic                      s2_vld_r, s2_hi_r, s2_en_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [OUT_W-1:0]   acc_r;
  logic signed [OUT_W-1:0]   out_data_r;
  logic                      out_valid_r;

  logic                          in_xfer, load_xfer, smp_xfer, cfg_wr, rot_en, mac_last;
  logic                          out_load;
  logic [TAPCNT_W-1:0]           active;
  logic [fir_pkg::COEF_W-1:0]    ram_rdata;
  logic signed [fir_pkg::COEF_W-1:0] coef_eff;
  logic signed [OUT_W-1:0]       p_ext, p_add;

  // handshake decode
  assign in_ready  = (state_r == fir_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign load_xfer = in_xfer && (in_req_type == fir_pkg::REQ_LOAD)
                     && (int'(in_coef_index) < fir_pkg::MAX_TAPS);
  assign smp_xfer  = in_xfer && (in_req_type == fir_pkg::REQ_SAMPLE);

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fir_pkg::TAPCNT_RESET;
    end else if (cfg_wr && (paddr[2] == fir_pkg::REG_TAP_COUNT)) begin
      tap_count_r <= pwdata[TAPCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == fir_pkg::REG_TAP_COUNT) begin
      prdata = {{(fir_pkg::PDATA_W-TAPCNT_W){1'b0}}, tap_count_r};
    end
  end

  // clamp tap count to the store depth
  assign active = (tap_count_r > TAPCNT_W'(fir_pkg::MAX_TAPS)) ?
                  TAPCNT_W'(fir_pkg::MAX_TAPS) : tap_count_r;

  // sequencer
  assign mac_last = (tap_r == TAP_W'(fir_pkg::MAX_TAPS - 1)) && digit_r;
  assign out_load = (state_r == fir_pkg::ST_WRAP) && !s1_vld_r && !s2_vld_r
                    && (!out_valid_r || out_ready);
  assign rot_en   = (state_r == fir_pkg::ST_MAC) && digit_r;

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    digit_nxt = digit_r;
    case (state_r)
      fir_pkg::ST_IDLE: begin
        tap_nxt   = '0;
        digit_nxt = 1'b0;
        if (smp_xfer) begin
          state_nxt = fir_pkg::ST_MAC;
        end
      end
      fir_pkg::ST_MAC: begin
        digit_nxt = !digit_r;
        if (digit_r) begin
          tap_nxt = tap_r + TAP_W'(1);
        end
        if (mac_last) begin
          state_nxt = fir_pkg::ST_WRAP;
        end
      end
      fir_pkg::ST_WRAP: begin
        if (out_load) begin
          state_nxt = fir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir_pkg::ST_IDLE;
      tap_r   <= '0;
      digit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      digit_r <= digit_nxt;
    end
  end

  // delay line: push on a sample, rotate one place per tap after its high digit, tap 0 is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fir_pkg::MAX_TAPS; i++) begin
        dl_r[i] <= '0;
      end
    end else if (smp_xfer) begin
      dl_r[0] <= in_sample_in;
      for (int i = 1; i < fir_pkg::MAX_TAPS; i++) begin
        dl_r[i] <= dl_r[i-1];
      end
    end else if (rot_en) begin
      for (int i = 0; i < fir_pkg::MAX_TAPS - 1; i++) begin
        dl_r[i] <= dl_r[i+1];
      end
      dl_r[fir_pkg::MAX_TAPS-1] <= dl_r[0];
    end
  end

  // coefficient store; never-written entries read as zero
  fir_ram #(
    .WIDTH (fir_pkg::COEF_W),
    .DEPTH (fir_pkg::MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (load_xfer),
    .waddr (in_coef_index[TAP_W-1:0]),
    .wdata (in_coef_value),
    .raddr (tap_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
    end else if (load_xfer) begin
      coef_vld_r[in_coef_index[TAP_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_rd_r <= coef_vld_r[tap_r];
  end

  // stage 1: pick the sample digit alongside the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == fir_pkg::ST_MAC);
    end
    s1_hi_r    <= digit_r;
    s1_en_r    <= ({{(TAPCNT_W-TAP_W){1'b0}}, tap_r} < active);
    s1_digit_r <= digit_r ? {dl_r[0][fir_pkg::SAMPLE_W-1], dl_r[0][fir_pkg::SAMPLE_W-1 -: DIGIT_W]}
                          : {1'b0, dl_r[0][DIGIT_W-1:0]};
  end

  // stage 2: coefficient times digit
  assign coef_eff = vld_rd_r ? $signed(ram_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_hi_r <= s1_hi_r;
    s2_en_r <= s1_en_r;
    p_r     <= coef_eff * s1_digit_r;
  end

  // stage 3: accumulate, high digit weighted by 2^8
  assign p_ext = {{(OUT_W-PROD_W){p_r[PROD_W-1]}}, p_r};
  assign p_add = s2_hi_r ? {p_ext[OUT_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} : p_ext;

  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      acc_r <= '0;
    end else if (s2_vld_r && s2_en_r) begin
      acc_r <= acc_r + p_add;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= acc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_filtered_out = out_data_r;

  // checks
  `FIR_ASSERT_NEXT(a_smp_starts_mac, smp_xfer,
    (state_r == fir_pkg::ST_MAC) && (tap_r == '0) && !digit_r,
    "sample transfer did not start the mac at tap zero")
  `FIR_ASSERT_SAME(a_pipe_order, s2_vld_r, $past(s1_vld_r),
    "product stage valid without a preceding issue")
  `FIR_ASSERT_NEXT(a_load_marks_valid, load_xfer,
    coef_vld_r[$past(in_coef_index[TAP_W-1:0])],
    "coefficient load did not mark its entry valid")

endmodule

`default_nettype wire
